// File: src/triangle_raster_depth_test_top_macros.svh
// Assertion macros for the triangle rasterizer checker.
// Used by trd_checker; expects clk and rst in scope.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_TOP_MACROS_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_TOP_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define TRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define TRD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/trd_pkg.sv
// Shared constants, codes and interface structs of the triangle rasterizer.
// No dependencies.
package trd_pkg;

  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;
  localparam int SUBPIXEL_BITS    = 4;
  localparam int DEPTH_FRAC_BITS  = 16;

  localparam int COORD_W = 16;
  localparam int COL_W   = COORD_W - SUBPIXEL_BITS;
  localparam int DEPTH_W = DEPTH_FRAC_BITS + 1;
  localparam int COLOR_W = 32;
  localparam int COUNT_W = 17;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int EDGE_W  = PROD_W + 1;
  localparam int WGT_W   = 17;
  localparam int RCP_W   = 33;
  localparam int PBR_W   = WGT_W + RCP_W;
  localparam int SUM_W   = PBR_W + 1;

  localparam int DIV_NW = 52;
  localparam int DIV_DW = 51;
  localparam int DIV_QW = 33;
  localparam int DIV_CW = 6;

  localparam logic [SUBPIXEL_BITS-1:0] SUB_HALF = SUBPIXEL_BITS'(1 << (SUBPIXEL_BITS - 1));
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1 << DEPTH_FRAC_BITS);
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [DIV_CW-1:0] Q_RECIP = DIV_CW'(33);
  localparam logic [DIV_CW-1:0] Q_WGT   = DIV_CW'(17);
  localparam logic [DIV_CW-1:0] Q_DEPTH = DIV_CW'(18);
  localparam logic [DIV_CW-1:0] Q_COLOR = DIV_CW'(8);

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] qbits;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_sts_t;

  typedef struct packed {
    logic we_color;
    logic we_depth;
    logic re;
  } mem_ctl_t;

endpackage

// File: src/trd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on trd_pkg. The caller states how many quotient bits to form.
module trd_div import trd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output div_sts_t          sts,
  output logic [DIV_QW-1:0] quo
);

  logic [DIV_NW-1:0] rem;
  logic [DIV_NW-1:0] low;
  logic [DIV_NW-1:0] trial;
  logic [DIV_NW-1:0] den_x;
  logic [DIV_NW-1:0] num_hi;
  logic [DIV_CW-1:0] left;
  logic              active;
  logic              done;
  logic              ovf;

  assign den_x  = {1'b0, den};
  assign trial  = {rem[DIV_NW-2:0], low[DIV_NW-1]};
  assign num_hi = num >> ctl.qbits;
  assign sts    = '{done: done, ovf: ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      left   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        active <= 1'b1;
        left   <= ctl.qbits;
      end else if (active) begin
        left <= left - 1'b1;
        if (left == DIV_CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // A remainder that starts at or above the divisor means the quotient does not fit.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= num_hi;
      low <= num << (DIV_CW'(DIV_NW) - ctl.qbits);
      quo <= '0;
      ovf <= (num_hi >= den_x);
    end else if (active) begin
      low <= {low[DIV_NW-2:0], 1'b0};
      if (trial >= den_x) begin
        rem <= trial - den_x;
        quo <= {quo[DIV_QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DIV_QW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: src/trd_store.sv
// Color and depth frame stores, one write and one registered read port each.
// Depends on trd_pkg.
module trd_store import trd_pkg::*; #(
  parameter int PIX = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
  parameter int AW  = $clog2(PIX)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [AW-1:0]      raddr,
  input  logic [COLOR_W-1:0] wcolor,
  input  logic [DEPTH_W-1:0] wdepth,
  output logic [COLOR_W-1:0] rcolor,
  output logic [DEPTH_W-1:0] rdepth
);

  logic [COLOR_W-1:0] color_mem [PIX];
  logic [DEPTH_W-1:0] depth_mem [PIX];

  always_ff @(posedge clk) begin
    if (ctl.we_color) begin
      color_mem[waddr] <= wcolor;
    end
    if (ctl.we_depth) begin
      depth_mem[waddr] <= wdepth;
    end
    if (ctl.re) begin
      rcolor <= color_mem[raddr];
      rdepth <= depth_mem[raddr];
    end
  end

endmodule

// File: src/trd_engine.sv
// Request sequencer and pixel datapath: edge functions, bounding box scan,
// depth read-compare-write. Depends on trd_pkg, drives trd_div and trd_store.
module trd_engine import trd_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int PIX          = FRAME_WIDTH * FRAME_HEIGHT,
  parameter int AW           = $clog2(PIX)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [COORD_W-1:0] v0_x,
  input  logic [COORD_W-1:0] v0_y,
  input  logic [DEPTH_W-1:0] v0_z,
  input  logic [COORD_W-1:0] v1_x,
  input  logic [COORD_W-1:0] v1_y,
  input  logic [DEPTH_W-1:0] v1_z,
  input  logic [COORD_W-1:0] v2_x,
  input  logic [COORD_W-1:0] v2_y,
  input  logic [DEPTH_W-1:0] v2_z,
  input  logic [COLOR_W-1:0] flat_color,
  input  logic               use_barycentric,
  output logic               done,
  output logic [COLOR_W-1:0] pixel_color,
  output logic [DEPTH_W-1:0] pixel_depth,
  output logic [COUNT_W-1:0] pixels_written,
  output div_ctl_t           div_ctl,
  output logic [DIV_NW-1:0]  div_num,
  output logic [DIV_DW-1:0]  div_den,
  input  div_sts_t           div_sts,
  input  logic [DIV_QW-1:0]  div_quo,
  output mem_ctl_t           mem_ctl,
  output logic [AW-1:0]      mem_waddr,
  output logic [AW-1:0]      mem_raddr,
  output logic [COLOR_W-1:0] mem_wcolor,
  output logic [DEPTH_W-1:0] mem_wdepth,
  input  logic [COLOR_W-1:0] mem_rcolor,
  input  logic [DEPTH_W-1:0] mem_rdepth
);

  typedef enum logic [18:0] {
    S_INIT  = 19'h00001,
    S_IDLE  = 19'h00002,
    S_CLEAR = 19'h00004,
    S_RADDR = 19'h00008,
    S_RREAD = 19'h00010,
    S_RDATA = 19'h00020,
    S_AREA  = 19'h00040,
    S_BOX   = 19'h00080,
    S_RECIP = 19'h00100,
    S_ROWB  = 19'h00200,
    S_EDGE  = 19'h00400,
    S_WGT   = 19'h00800,
    S_SUM   = 19'h01000,
    S_ZDIV  = 19'h02000,
    S_COLOR = 19'h04000,
    S_RDZ   = 19'h08000,
    S_CMP   = 19'h10000,
    S_NEXT  = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [COL_W-1:0] ROW_LAST = COL_W'(FRAME_HEIGHT - 1);
  localparam logic [AW-1:0]    SWEEP_LAST = AW'(PIX - 1);

  state_t state;
  logic [AW-1:0]      sweep;
  logic [2:0]         step;
  logic [1:0]         kidx;
  logic               issued;

  logic [COORD_W-1:0] vx [3];
  logic [COORD_W-1:0] vy [3];
  logic [DEPTH_W-1:0] vz [3];
  logic [COLOR_W-1:0] flat;
  logic               bary;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] first;
  logic signed [EDGE_W-1:0] area;
  logic signed [EDGE_W-1:0] w [3];
  logic signed [EDGE_W-1:0] edge_val;

  logic [COL_W-1:0]   xlo, xhi, yhi, col, row;
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      pix_addr;
  logic [AW-1:0]      rd_addr;
  logic               rd_ok;
  logic [RCP_W-1:0]   rcp [3];
  logic [WGT_W-1:0]   wgt [3];
  logic [PBR_W-1:0]   bprod;
  logic [SUM_W-1:0]   sum_acc;
  logic [DEPTH_W-1:0] zval;
  logic [7:0]         rgb [3];
  logic [COUNT_W-1:0] cnt;
  logic [COLOR_W-1:0] res_color;
  logic [DEPTH_W-1:0] res_depth;

  logic [1:0]               mul_edge;
  logic [COORD_W-1:0]       cx, cy, bx, by, ax, ay, px, py;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic [COORD_W-1:0]       xmin, xmax, ymin, ymax;
  logic [COL_W-1:0]         xhi_c, yhi_c;
  logic [EDGE_W-1:0]        w_sel;
  logic [DEPTH_W-1:0]       z_sel;
  logic [WGT_W-1:0]         sum_w;
  logic [RCP_W-1:0]         sum_r;
  logic                     div_state;
  logic                     div_last;
  logic [COLOR_W-1:0]       draw_color;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_W-1:0] p,
                                                     input logic [COORD_W-1:0] q);
    return $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b,
                                              input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b,
                                              input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign busy     = (state != S_IDLE);
  assign px       = {col, SUB_HALF};
  assign py       = {row, SUB_HALF};
  assign pix_addr = row_base + AW'(col);
  assign edge_val = EDGE_W'(first) - EDGE_W'(prod);

  // Edges 0..2 are the pixel weights, edge 3 is the triangle area.
  assign mul_edge = (state == S_AREA) ? 2'd3 : step[2:1];

  always_comb begin
    case (mul_edge)
      2'd0: begin
        cx = px; cy = py; bx = vx[2]; by = vy[2]; ax = vx[1]; ay = vy[1];
      end
      2'd1: begin
        cx = px; cy = py; bx = vx[0]; by = vy[0]; ax = vx[2]; ay = vy[2];
      end
      2'd2: begin
        cx = px; cy = py; bx = vx[1]; by = vy[1]; ax = vx[0]; ay = vy[0];
      end
      default: begin
        cx = vx[2]; cy = vy[2]; bx = vx[1]; by = vy[1]; ax = vx[0]; ay = vy[0];
      end
    endcase
    if (step[0]) begin
      mul_a = sdiff(cy, ay);
      mul_b = sdiff(bx, ax);
    end else begin
      mul_a = sdiff(cx, ax);
      mul_b = sdiff(by, ay);
    end
  end

  always_comb begin
    xmin  = min3(vx[0], vx[1], vx[2]);
    xmax  = max3(vx[0], vx[1], vx[2]);
    ymin  = min3(vy[0], vy[1], vy[2]);
    ymax  = max3(vy[0], vy[1], vy[2]);
    xhi_c = (xmax[COORD_W-1:SUBPIXEL_BITS] > COL_LAST) ? COL_LAST :
            xmax[COORD_W-1:SUBPIXEL_BITS];
    yhi_c = (ymax[COORD_W-1:SUBPIXEL_BITS] > ROW_LAST) ? ROW_LAST :
            ymax[COORD_W-1:SUBPIXEL_BITS];
  end

  always_comb begin
    w_sel = w[kidx];
    z_sel = (vz[kidx] == '0) ? DEPTH_W'(1) : vz[kidx];
    case (step[1:0])
      2'd0:    begin sum_w = wgt[0]; sum_r = rcp[0]; end
      2'd1:    begin sum_w = wgt[1]; sum_r = rcp[1]; end
      default: begin sum_w = wgt[2]; sum_r = rcp[2]; end
    endcase
  end

  // Divider operand selection for the four kinds of division.
  always_comb begin
    div_state = 1'b1;
    div_num   = '0;
    div_den   = '0;
    div_ctl.qbits = Q_WGT;
    case (state)
      S_RECIP: begin
        div_num = DIV_NW'(64'd1 << 32);
        div_den = DIV_DW'(z_sel);
        div_ctl.qbits = Q_RECIP;
      end
      S_WGT: begin
        div_num = DIV_NW'({w_sel, 16'h0000});
        div_den = DIV_DW'(area);
        div_ctl.qbits = Q_WGT;
      end
      S_ZDIV: begin
        div_num = DIV_NW'(64'd1 << 48);
        div_den = sum_acc;
        div_ctl.qbits = Q_DEPTH;
      end
      S_COLOR: begin
        div_num = DIV_NW'({w_sel, 8'h00}) - DIV_NW'(w_sel);
        div_den = DIV_DW'(area);
        div_ctl.qbits = Q_COLOR;
      end
      default: div_state = 1'b0;
    endcase
    div_ctl.start = div_state && !issued;
    div_last      = (state == S_ZDIV) || (kidx == 2'd2);
  end

  assign draw_color = bary ? {8'hFF, rgb[0], rgb[1], rgb[2]} : flat;

  always_comb begin
    mem_ctl.we_color = (state == S_INIT) ||
                       ((state == S_CMP) && (zval < mem_rdepth));
    mem_ctl.we_depth = (state == S_INIT) || (state == S_CLEAR) ||
                       ((state == S_CMP) && (zval < mem_rdepth));
    mem_ctl.re       = (state == S_RREAD) || (state == S_RDZ);
    mem_waddr  = ((state == S_INIT) || (state == S_CLEAR)) ? sweep : pix_addr;
    mem_raddr  = (state == S_RREAD) ? rd_addr : pix_addr;
    mem_wcolor = (state == S_INIT) ? '0 : draw_color;
    mem_wdepth = ((state == S_INIT) || (state == S_CLEAR)) ? DEPTH_ONE : zval;
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    bprod <= PBR_W'(sum_w * sum_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      sweep  <= '0;
      step   <= '0;
      kidx   <= '0;
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SWEEP_LAST) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (start) begin
            vx[0] <= v0_x; vy[0] <= v0_y; vz[0] <= v0_z;
            vx[1] <= v1_x; vy[1] <= v1_y; vz[1] <= v1_z;
            vx[2] <= v2_x; vy[2] <= v2_y; vz[2] <= v2_z;
            flat      <= flat_color;
            bary      <= use_barycentric;
            res_color <= '0;
            res_depth <= '0;
            cnt       <= '0;
            step      <= '0;
            kidx      <= '0;
            issued    <= 1'b0;
            sweep     <= '0;
            case (req_type)
              REQ_DRAW:  state <= S_AREA;
              REQ_READ:  state <= S_RADDR;
              REQ_CLEAR: state <= S_CLEAR;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_RADDR: begin
          col     <= vx[0][COORD_W-1:SUBPIXEL_BITS];
          row     <= vy[0][COORD_W-1:SUBPIXEL_BITS];
          rd_ok   <= (int'(vx[0][COORD_W-1:SUBPIXEL_BITS]) < FRAME_WIDTH) &&
                     (int'(vy[0][COORD_W-1:SUBPIXEL_BITS]) < FRAME_HEIGHT);
          rd_addr <= AW'(int'(vy[0][COORD_W-1:SUBPIXEL_BITS]) * FRAME_WIDTH +
                         int'(vx[0][COORD_W-1:SUBPIXEL_BITS]));
          state   <= S_RREAD;
        end
        S_RREAD: state <= S_RDATA;
        S_RDATA: begin
          res_color <= rd_ok ? mem_rcolor : '0;
          res_depth <= rd_ok ? mem_rdepth : '0;
          state     <= S_DONE;
        end
        S_AREA: begin
          step <= step + 1'b1;
          if (step == 3'd1) begin
            first <= prod;
          end
          if (step == 3'd2) begin
            area  <= edge_val;
            step  <= '0;
            state <= S_BOX;
          end
        end
        S_BOX: begin
          xlo <= xmin[COORD_W-1:SUBPIXEL_BITS];
          col <= xmin[COORD_W-1:SUBPIXEL_BITS];
          row <= ymin[COORD_W-1:SUBPIXEL_BITS];
          xhi <= xhi_c;
          yhi <= yhi_c;
          // Degenerate or back-facing triangles and boxes off the frame draw nothing.
          if (area[EDGE_W-1] || (area == '0) ||
              (xmin[COORD_W-1:SUBPIXEL_BITS] > xhi_c) ||
              (ymin[COORD_W-1:SUBPIXEL_BITS] > yhi_c)) begin
            state <= S_DONE;
          end else begin
            state <= S_RECIP;
          end
        end
        S_RECIP, S_WGT, S_ZDIV, S_COLOR: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (div_sts.done) begin
            issued <= 1'b0;
            kidx   <= div_last ? 2'd0 : kidx + 1'b1;
            case (state)
              S_RECIP: begin
                rcp[kidx] <= div_quo;
                if (div_last) state <= S_ROWB;
              end
              S_WGT: begin
                wgt[kidx] <= div_quo[WGT_W-1:0];
                if (div_last) begin
                  step  <= '0;
                  state <= S_SUM;
                end
              end
              S_ZDIV: begin
                zval  <= (div_sts.ovf || (div_quo > DIV_QW'(DEPTH_SAT))) ? DEPTH_SAT :
                         div_quo[DEPTH_W-1:0];
                state <= bary ? S_COLOR : S_RDZ;
              end
              default: begin
                rgb[kidx] <= div_quo[7:0];
                if (div_last) state <= S_RDZ;
              end
            endcase
          end
        end
        S_ROWB: begin
          row_base <= AW'(int'(row) * FRAME_WIDTH);
          step     <= '0;
          state    <= S_EDGE;
        end
        S_EDGE: begin
          // Two products per edge through the one multiplier, then the difference.
          step <= step + 1'b1;
          if (step[0]) begin
            first <= prod;
          end else if (step != 3'd0 && step != 3'd7) begin
            w[step[2:1] - 2'd1] <= edge_val;
          end
          if (step == 3'd7) begin
            step  <= '0;
            state <= (w[0][EDGE_W-1] || w[1][EDGE_W-1] || w[2][EDGE_W-1]) ?
                     S_NEXT : S_WGT;
          end
        end
        S_SUM: begin
          step <= step + 1'b1;
          if (step == 3'd0) begin
            sum_acc <= '0;
          end else begin
            sum_acc <= sum_acc + SUM_W'(bprod);
          end
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_ZDIV;
          end
        end
        S_RDZ: state <= S_CMP;
        S_CMP: begin
          if ((zval < mem_rdepth) && (cnt != COUNT_SAT)) begin
            cnt <= cnt + 1'b1;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          step <= '0;
          if (col == xhi) begin
            if (row == yhi) begin
              state <= S_DONE;
            end else begin
              row      <= row + 1'b1;
              col      <= xlo;
              row_base <= row_base + AW'(FRAME_WIDTH);
              state    <= S_EDGE;
            end
          end else begin
            col   <= col + 1'b1;
            state <= S_EDGE;
          end
        end
        S_DONE: begin
          done           <= 1'b1;
          pixel_color    <= res_color;
          pixel_depth    <= res_depth;
          pixels_written <= cnt;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/triangle_raster_depth_test_top.sv
// Triangle rasterizer with depth test: one request at a time, held off while
// busy is high; each request gives one result word marked by done for one cycle,
// and the receiver must take it then. After reset busy stays high while both
// stores are swept to their reset values; a depth clear runs the same sweep.
// A pixel read goes through address, read and data states. A draw first forms
// three reciprocals through the shared bit-serial divider, then scans the box:
// a pixel outside the triangle only gets its edge functions, a pixel inside also
// gets its weights and depth (and in barycentric mode its color) from the shared
// divider, one quotient bit per cycle.
// Depends on trd_pkg, trd_engine, trd_div and trd_store.
module triangle_raster_depth_test_top import trd_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [COORD_W-1:0] v0_x,
  input  logic [COORD_W-1:0] v0_y,
  input  logic [DEPTH_W-1:0] v0_z,
  input  logic [COORD_W-1:0] v1_x,
  input  logic [COORD_W-1:0] v1_y,
  input  logic [DEPTH_W-1:0] v1_z,
  input  logic [COORD_W-1:0] v2_x,
  input  logic [COORD_W-1:0] v2_y,
  input  logic [DEPTH_W-1:0] v2_z,
  input  logic [COLOR_W-1:0] flat_color,
  input  logic               use_barycentric,
  output logic               done,
  output logic [COLOR_W-1:0] pixel_color,
  output logic [DEPTH_W-1:0] pixel_depth,
  output logic [COUNT_W-1:0] pixels_written
);

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);

  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic [DIV_QW-1:0]  div_quo;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [COLOR_W-1:0] mem_wcolor;
  logic [DEPTH_W-1:0] mem_wdepth;
  logic [COLOR_W-1:0] mem_rcolor;
  logic [DEPTH_W-1:0] mem_rdepth;

  trd_engine #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .PIX          (PIX),
    .AW           (AW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .v0_x            (v0_x),
    .v0_y            (v0_y),
    .v0_z            (v0_z),
    .v1_x            (v1_x),
    .v1_y            (v1_y),
    .v1_z            (v1_z),
    .v2_x            (v2_x),
    .v2_y            (v2_y),
    .v2_z            (v2_z),
    .flat_color      (flat_color),
    .use_barycentric (use_barycentric),
    .done            (done),
    .pixel_color     (pixel_color),
    .pixel_depth     (pixel_depth),
    .pixels_written  (pixels_written),
    .div_ctl         (div_ctl),
    .div_num         (div_num),
    .div_den         (div_den),
    .div_sts         (div_sts),
    .div_quo         (div_quo),
    .mem_ctl         (mem_ctl),
    .mem_waddr       (mem_waddr),
    .mem_raddr       (mem_raddr),
    .mem_wcolor      (mem_wcolor),
    .mem_wdepth      (mem_wdepth),
    .mem_rcolor      (mem_rcolor),
    .mem_rdepth      (mem_rdepth)
  );

  trd_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (div_num),
    .den (div_den),
    .sts (div_sts),
    .quo (div_quo)
  );

  trd_store #(
    .PIX (PIX),
    .AW  (AW)
  ) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (mem_waddr),
    .raddr  (mem_raddr),
    .wcolor (mem_wcolor),
    .wdepth (mem_wdepth),
    .rcolor (mem_rcolor),
    .rdepth (mem_rdepth)
  );

endmodule

// File: src/trd_checker.sv
// Port-level checker for the triangle rasterizer, bound to the top level.
// Depends on triangle_raster_depth_test_top_macros.svh.
`include "triangle_raster_depth_test_top_macros.svh"

module trd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] pixel_color,
  input logic [16:0] pixel_depth,
  input logic [16:0] pixels_written
);

  `TRD_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `TRD_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
  `TRD_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `TRD_ASSERT(a_reset_sweep, $past(rst) |-> busy, "not busy with the store sweep after reset")
  `TRD_ASSERT_NEVER(a_field_mix, done && (pixels_written != 17'd0) && ((pixel_color != 32'd0) || (pixel_depth != 17'd0)), "draw count and pixel read in one result")

endmodule

bind triangle_raster_depth_test_top trd_checker u_checker (.*);
